// ----- design/g2e_pkg.sv -----
// ----------------------------------------------------------------------------
// g2e_pkg
// Shared types, constants and the rounded 1.30 product for the geodetic to
// local east/north/up converter.
// ----------------------------------------------------------------------------
`default_nettype none

package g2e_pkg;

  // Pipeline depths
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 33;

  // Stage numbers inside the ECEF pipeline (input register is stage 1)
  localparam int T_TRIG       = 1 + CORDIC_STEPS + 1;
  localparam int T_ROOT       = T_TRIG + 2 + SQRT_STEPS;
  localparam int T_QUOT       = T_ROOT + 1 + DIV_STEPS;
  localparam int ECEF_LATENCY = T_QUOT + 4;
  localparam int ENU_LATENCY  = ECEF_LATENCY + 3;

  // Sine/cosine in 1.30, positions in mm
  typedef logic signed [32:0] trig_val_t;
  typedef logic signed [39:0] mm_t;

  typedef struct packed {
    trig_val_t sin_lat;
    trig_val_t cos_lat;
    trig_val_t sin_lon;
    trig_val_t cos_lon;
  } trig_t;

  typedef struct packed {
    mm_t x;
    mm_t y;
    mm_t z;
  } pos_t;

  // 1e-7 degree to 2^32-per-turn phase, scaled by 2^30
  localparam logic signed [31:0] DEG_TO_PHASE = 32'sd1281023894;
  localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
  localparam logic [32:0]        E2_Q40       = 33'd7360548655;
  localparam logic [63:0]        A_MM_Q31     = 64'd6378137000 << 31;

  // Arctangent of 2^-i in phase units
  localparam logic [29:0] ATAN_PHASE [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  // round(a * b / 2^30): a split at bit 15, low partial and sum each rounded half up
  function automatic mm_t mul_q30(input mm_t a, input trig_val_t b);
    logic signed [24:0] hi;
    logic signed [15:0] lo;
    logic signed [57:0] ph;
    logic signed [48:0] pl;
    logic signed [59:0] t;
    logic signed [59:0] rs;
    begin
      hi = a[39:15];
      lo = signed'({1'b0, a[14:0]});
      ph = hi * b;
      pl = lo * b;
      t  = 60'(ph) + 60'((pl + 49'sd16384) >>> 15);
      rs = (t + 60'sd16384) >>> 15;
      return rs[39:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/geodetic_to_local_enu_core.sv -----
// Throughput: one request per cycle; the whole pipeline holds when the
//   output register is full and not taken.
// Reset: clears all valid bits and loads the default reference point.
// ----------------------------------------------------------------------------
// geodetic_to_local_enu_core
// WGS-84 fix to local east/north/up in mm relative to a configured reference,
// saturated to signed 32 bits with a clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

module geodetic_to_local_enu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // latitude[30:0], longitude[62:31], altitude[90:63]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // east[31:0], north[63:32], up[95:64]
  output logic        m_tuser,   // saturated[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    REG_REF_LATITUDE  = 2'd0,
    REG_REF_LONGITUDE = 2'd1,
    REG_REF_HEIGHT    = 2'd2
  } reg_idx_t;

  localparam int LAT = g2e_pkg::ENU_LATENCY;

  // Configuration registers
  logic signed [30:0] ref_latitude;
  logic signed [31:0] ref_longitude;
  logic signed [27:0] ref_height;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_latitude  <= 31'sd456311926;
      ref_longitude <= 32'sd92947495;
      ref_height    <= 28'sd231507;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_REF_LATITUDE:  ref_latitude  <= pwdata[30:0];
        REG_REF_LONGITUDE: ref_longitude <= pwdata;
        REG_REF_HEIGHT:    ref_height    <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_REF_LATITUDE:  prdata = 32'(ref_latitude);
      REG_REF_LONGITUDE: prdata = ref_longitude;
      REG_REF_HEIGHT:    prdata = 32'(ref_height);
      default:           prdata = '0;
    endcase
  end

  // Pipeline advance and valid bits
  logic           advance;
  logic [LAT:1]   vld;

  assign m_tvalid = vld[LAT];
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-1:1], s_tvalid};
    end
  end

  // Fix and reference through identical ECEF pipelines
  g2e_pkg::pos_t  fix_pos, ref_pos;
  g2e_pkg::trig_t ref_trig;

  g2e_ecef u_fix (
    .clk  (clk),
    .en   (advance),
    .lat  (signed'(s_tdata[30:0])),
    .lon  (signed'(s_tdata[62:31])),
    .hgt  (signed'(s_tdata[90:63])),
    .pos  (fix_pos),
    .trig ()
  );

  g2e_ecef u_ref (
    .clk  (clk),
    .en   (advance),
    .lat  (ref_latitude),
    .lon  (ref_longitude),
    .hgt  (ref_height),
    .pos  (ref_pos),
    .trig (ref_trig)
  );

  // Differences and rotation coefficients
  g2e_pkg::mm_t       dx, dy, dz;
  g2e_pkg::trig_val_t k_cs, k_ss, k_cc, k_co, nso, co0, cl0, sl0;

  always_ff @(posedge clk) begin
    if (advance) begin
      dx   <= fix_pos.x - ref_pos.x;
      dy   <= fix_pos.y - ref_pos.y;
      dz   <= fix_pos.z - ref_pos.z;
      k_cs <= 33'(g2e_pkg::mul_q30(40'(ref_trig.cos_lon), ref_trig.sin_lat));
      k_ss <= 33'(g2e_pkg::mul_q30(40'(ref_trig.sin_lat), ref_trig.sin_lon));
      k_cc <= 33'(g2e_pkg::mul_q30(40'(ref_trig.cos_lat), ref_trig.cos_lon));
      k_co <= 33'(g2e_pkg::mul_q30(40'(ref_trig.cos_lat), ref_trig.sin_lon));
      nso  <= -ref_trig.sin_lon;
      co0  <= ref_trig.cos_lon;
      cl0  <= ref_trig.cos_lat;
      sl0  <= ref_trig.sin_lat;
    end
  end

  // Rotation terms
  g2e_pkg::mm_t te1, te2, tn1, tn2, tn3, tu1, tu2, tu3;

  always_ff @(posedge clk) begin
    if (advance) begin
      te1 <= g2e_pkg::mul_q30(dx, nso);
      te2 <= g2e_pkg::mul_q30(dy, co0);
      tn1 <= g2e_pkg::mul_q30(dx, k_cs);
      tn2 <= g2e_pkg::mul_q30(dy, k_ss);
      tn3 <= g2e_pkg::mul_q30(dz, cl0);
      tu1 <= g2e_pkg::mul_q30(dx, k_cc);
      tu2 <= g2e_pkg::mul_q30(dy, k_co);
      tu3 <= g2e_pkg::mul_q30(dz, sl0);
    end
  end

  // Sums and saturation into the output register
  function automatic logic [31:0] clip32(input logic signed [41:0] v);
    begin
      if (v > 42'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -42'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    end
  endfunction

  function automatic logic over32(input logic signed [41:0] v);
    begin
      return (v > 42'sd2147483647) || (v < -42'sd2147483648);
    end
  endfunction

  logic signed [41:0] e_sum, n_sum, u_sum;

  always_comb begin
    e_sum = 42'(te1) + 42'(te2);
    n_sum = 42'(tn3) - 42'(tn1) - 42'(tn2);
    u_sum = 42'(tu1) + 42'(tu2) + 42'(tu3);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {clip32(u_sum), clip32(n_sum), clip32(e_sum)};
      m_tuser <= over32(e_sum) || over32(n_sum) || over32(u_sum);
    end
  end

`ifndef SYNTHESIS
  // A held pipeline keeps its valid bits
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld))
    else $error("valid bits moved during a stall");

  // Clip flag only with a field at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
       m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
       m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000))
    else $error("saturated flag without a clipped field");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- design/g2e_ecef.sv -----
// ----------------------------------------------------------------------------
// g2e_ecef
// Pipelined geodetic to Earth-centred conversion: phase, CORDIC sine/cosine,
// prime vertical radius through a bitwise root and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_ecef (
  input  logic                clk,
  input  logic                en,
  input  logic signed [30:0]  lat,
  input  logic signed [31:0]  lon,
  input  logic signed [27:0]  hgt,
  output g2e_pkg::pos_t       pos,
  output g2e_pkg::trig_t      trig
);

  localparam int LAST_ROT = g2e_pkg::CORDIC_STEPS - 1;
  localparam int LAST_SQ  = g2e_pkg::SQRT_STEPS - 1;
  localparam int LAST_DIV = g2e_pkg::DIV_STEPS - 1;
  localparam int TD_LEN   = g2e_pkg::ECEF_LATENCY - g2e_pkg::T_TRIG + 1;
  localparam int HD_LEN   = g2e_pkg::T_QUOT + 1;

  // Angle to phase
  logic signed [31:0] lat_s;
  logic signed [63:0] lat_prod, lon_prod, lat_rnd, lon_rnd;
  logic [31:0]        ph [2];
  logic signed [27:0] hd [HD_LEN];

  always_comb begin
    lat_s    = 32'(lat);
    lat_prod = lat_s * g2e_pkg::DEG_TO_PHASE;
    lon_prod = lon * g2e_pkg::DEG_TO_PHASE;
    lat_rnd  = lat_prod + 64'sd536870912;
    lon_rnd  = lon_prod + 64'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph[0] <= lat_rnd[61:30];
      ph[1] <= lon_rnd[61:30];
      hd[0] <= hgt;
      for (int k = 1; k < HD_LEN; k++) hd[k] <= hd[k-1];
    end
  end

  // CORDIC rotations, one per stage, latitude and longitude side by side
  g2e_pkg::trig_val_t cx [2][g2e_pkg::CORDIC_STEPS];
  g2e_pkg::trig_val_t cy [2][g2e_pkg::CORDIC_STEPS];
  logic signed [31:0] cz [2][g2e_pkg::CORDIC_STEPS];
  logic [1:0]         cq [2][g2e_pkg::CORDIC_STEPS];

  for (genvar j = 0; j < 2; j++) begin : g_axis
    for (genvar k = 0; k < g2e_pkg::CORDIC_STEPS; k++) begin : g_rot
      g2e_pkg::trig_val_t xi, yi;
      logic signed [31:0] zi;
      logic [1:0]         qi;
      if (k == 0) begin : g_first
        assign xi = g2e_pkg::CORDIC_GAIN;
        assign yi = '0;
        assign zi = signed'({2'b00, ph[j][29:0]});
        assign qi = ph[j][31:30];
      end else begin : g_next
        assign xi = cx[j][k-1];
        assign yi = cy[j][k-1];
        assign zi = cz[j][k-1];
        assign qi = cq[j][k-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          if (!zi[31]) begin
            cx[j][k] <= xi - (yi >>> k);
            cy[j][k] <= yi + (xi >>> k);
            cz[j][k] <= zi - signed'({2'b00, g2e_pkg::ATAN_PHASE[k]});
          end else begin
            cx[j][k] <= xi + (yi >>> k);
            cy[j][k] <= yi - (xi >>> k);
            cz[j][k] <= zi + signed'({2'b00, g2e_pkg::ATAN_PHASE[k]});
          end
          cq[j][k] <= qi;
        end
      end
    end
  end

  // Quadrant fold back
  g2e_pkg::trig_val_t sn [2];
  g2e_pkg::trig_val_t cs [2];
  g2e_pkg::trig_t     td [TD_LEN];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      case (cq[j][LAST_ROT])
        2'd0: begin
          cs[j] = cx[j][LAST_ROT];
          sn[j] = cy[j][LAST_ROT];
        end
        2'd1: begin
          cs[j] = -cy[j][LAST_ROT];
          sn[j] = cx[j][LAST_ROT];
        end
        2'd2: begin
          cs[j] = -cx[j][LAST_ROT];
          sn[j] = -cy[j][LAST_ROT];
        end
        default: begin
          cs[j] = cy[j][LAST_ROT];
          sn[j] = -cx[j][LAST_ROT];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td[0] <= '{sin_lat: sn[0], cos_lat: cs[0], sin_lon: sn[1], cos_lon: cs[1]};
      for (int k = 1; k < TD_LEN; k++) td[k] <= td[k-1];
    end
  end

  // sin^2 lat, then w = 1 - e2 sin^2 in Q40
  logic signed [65:0] sq;
  logic [35:0]        s2_raw;
  logic [30:0]        s2;
  logic [63:0]        e2s;
  logic [40:0]        w;

  always_comb begin
    sq     = td[0].sin_lat * td[0].sin_lat;
    s2_raw = sq[65:30];
    e2s    = g2e_pkg::E2_Q40 * s2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= (s2_raw > 36'h0_4000_0000) ? 31'h4000_0000 : s2_raw[30:0];
      w  <= 41'h100_0000_0000 - 41'(e2s[63:30]);
    end
  end

  // Bitwise root of w * 2^22, one result bit per stage
  logic [31:0] sr_root [g2e_pkg::SQRT_STEPS];
  logic [34:0] sr_rem  [g2e_pkg::SQRT_STEPS];
  logic [40:0] sr_w    [g2e_pkg::SQRT_STEPS];

  for (genvar k = 0; k < g2e_pkg::SQRT_STEPS; k++) begin : g_sqrt
    logic [31:0] rt_i, rt_s;
    logic [34:0] rm_i, rm_s;
    logic [40:0] w_i;
    logic [63:0] v;
    logic [34:0] trial;
    if (k == 0) begin : g_first
      assign rt_i = '0;
      assign rm_i = '0;
      assign w_i  = w;
    end else begin : g_next
      assign rt_i = sr_root[k-1];
      assign rm_i = sr_rem[k-1];
      assign w_i  = sr_w[k-1];
    end
    always_comb begin
      v     = {1'b0, w_i, 22'b0};
      rt_s  = {rt_i[30:0], 1'b0};
      rm_s  = {rm_i[32:0], v[63-2*k -: 2]};
      trial = {2'b00, rt_s, 1'b1};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial <= rm_s) begin
          sr_rem[k]  <= rm_s - trial;
          sr_root[k] <= rt_s | 32'd1;
        end else begin
          sr_rem[k]  <= rm_s;
          sr_root[k] <= rt_s;
        end
        sr_w[k] <= w_i;
      end
    end
  end

  // N = round(a * 2^31 / root): dividend with half divisor, then restoring divide
  logic [63:0] num;
  logic [31:0] dv;

  always_ff @(posedge clk) begin
    if (en) begin
      num <= g2e_pkg::A_MM_Q31 + {33'b0, sr_root[LAST_SQ][31:1]};
      dv  <= sr_root[LAST_SQ];
    end
  end

  logic [31:0] dd_rem [g2e_pkg::DIV_STEPS];
  logic [32:0] dd_q   [g2e_pkg::DIV_STEPS];
  logic [32:0] dd_num [g2e_pkg::DIV_STEPS];
  logic [31:0] dd_dv  [g2e_pkg::DIV_STEPS];

  for (genvar k = 0; k < g2e_pkg::DIV_STEPS; k++) begin : g_div
    logic [31:0] rem_i, d_i;
    logic [32:0] q_i, n_i, r2;
    if (k == 0) begin : g_first
      assign rem_i = {1'b0, num[63:33]};
      assign q_i   = '0;
      assign n_i   = num[32:0];
      assign d_i   = dv;
    end else begin : g_next
      assign rem_i = dd_rem[k-1];
      assign q_i   = dd_q[k-1];
      assign n_i   = dd_num[k-1];
      assign d_i   = dd_dv[k-1];
    end
    assign r2 = {rem_i, n_i[LAST_DIV-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= {1'b0, d_i}) begin
          dd_rem[k] <= 32'(r2 - {1'b0, d_i});
          dd_q[k]   <= {q_i[31:0], 1'b1};
        end else begin
          dd_rem[k] <= r2[31:0];
          dd_q[k]   <= {q_i[31:0], 1'b0};
        end
        dd_num[k] <= n_i;
        dd_dv[k]  <= d_i;
      end
    end
  end

  // e2 * N, radius sums, then the three coordinates
  logic [49:0]        e2_hi;
  logic [32:0]        e2_lo;
  logic [32:0]        n_rad;
  logic [48:0]        lo_prod;
  logic [50:0]        e2_sum;
  logic [26:0]        e2n;
  logic signed [34:0] r_a, r_b, rz;
  g2e_pkg::trig_val_t cc_x, cc_y;

  always_comb begin
    lo_prod = dd_q[LAST_DIV][15:0] * g2e_pkg::E2_Q40;
    e2_sum  = {1'b0, e2_hi} + 51'(e2_lo) + 51'h80_0000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_hi <= dd_q[LAST_DIV][32:16] * g2e_pkg::E2_Q40;
      e2_lo <= lo_prod[48:16];
      n_rad <= dd_q[LAST_DIV];
      e2n   <= e2_sum[50:24];
      r_a   <= 35'(hd[HD_LEN-1]) + signed'({2'b00, n_rad});
      rz    <= r_a - signed'({8'b0, e2n});
      r_b   <= r_a;
      cc_x  <= 33'(g2e_pkg::mul_q30(40'(td[TD_LEN-3].cos_lat), td[TD_LEN-3].cos_lon));
      cc_y  <= 33'(g2e_pkg::mul_q30(40'(td[TD_LEN-3].cos_lat), td[TD_LEN-3].sin_lon));
      pos.x <= g2e_pkg::mul_q30(40'(r_b), cc_x);
      pos.y <= g2e_pkg::mul_q30(40'(r_b), cc_y);
      pos.z <= g2e_pkg::mul_q30(40'(rz), td[TD_LEN-2].sin_lat);
    end
  end

  assign trig = td[TD_LEN-1];

endmodule

`default_nettype wire
